// File: hdl/gcm_pkg.sv
package gcm_pkg;

  // Word geometry and register map
  localparam int unsigned ChromBits      = 64;
  localparam int unsigned ShiftW         = $clog2(ChromBits);
  localparam int unsigned RoundsW        = 5;
  localparam int unsigned DefMaxRounds   = 16;
  localparam logic [RoundsW-1:0] ResetRounds = RoundsW'(6);
  localparam logic [ChromBits-1:0] ResetSeed = ChromBits'(1);

  localparam logic [0:0] RegRngSeed = 1'b0;
  localparam logic [0:0] RegMutRounds = 1'b1;

  // xorshift64* constants
  localparam logic [63:0] XsMult = 64'h2545_F491_4F6C_DD1D;
  localparam int unsigned XsShiftA = 12;
  localparam int unsigned XsShiftB = 25;
  localparam int unsigned XsShiftC = 27;

  // What the datapath does with one finished draw
  typedef enum logic [2:0] {
    OP_RECIPE_L,
    OP_RECIPE_R,
    OP_XO_SHIFT,
    OP_XO_MOTHER,
    OP_XO_FATHER,
    OP_SEX_SELECT,
    OP_MUT_L,
    OP_MUT_R
  } op_e;

  typedef struct packed {
    logic load;       // latch a new input word, clear mutation masks
    logic step;       // advance the generator, issue one draw
    logic use_draw;   // consume the draw at the pipeline end
    op_e  op;
    logic mut_first;  // first draw of a mutation mask
    logic out_load;   // move the finished word to the output register
  } cmd_t;

  typedef struct packed {
    logic draw_valid;
  } status_t;

endpackage

// File: hdl/gcm_dpath.sv
module gcm_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       seed_we_i,
  input  logic [gcm_pkg::ChromBits-1:0] seed_i,
  input  gcm_pkg::cmd_t              cmd_i,
  output gcm_pkg::status_t           status_o,
  input  logic [gcm_pkg::ChromBits-1:0] mother_left_i,
  input  logic [gcm_pkg::ChromBits-1:0] mother_right_i,
  input  logic [gcm_pkg::ChromBits-1:0] father_left_i,
  input  logic [gcm_pkg::ChromBits-1:0] father_right_i,
  input  logic [gcm_pkg::ChromBits-1:0] recipe_code_i,
  input  logic [gcm_pkg::ChromBits-1:0] recipe_mask_i,
  output logic [gcm_pkg::ChromBits-1:0] child_left_o,
  output logic [gcm_pkg::ChromBits-1:0] child_right_o
);
  import gcm_pkg::*;

  localparam logic [31:0] MultLo = XsMult[31:0];
  localparam logic [31:0] MultHi = XsMult[63:32];

  logic [63:0] rng_q, rng_next;
  logic [63:0] x1_q;
  logic [63:0] pll2_q, pll3_q, pll4_q;
  logic [31:0] xh2_q, xl2_q, xh3_q;
  logic [31:0] c1_3_q, c1_4_q, c2_4_q;
  logic [63:0] draw_q;
  logic [4:1]  v_q;
  logic        dv_q;

  logic [ChromBits-1:0] ml_in_q, mr_in_q, fl_in_q, fr_in_q, code_q, rmask_q;
  logic [ChromBits-1:0] left_q, right_q, mut_l_q, mut_r_q;
  logic [ChromBits-1:0] out_l_q, out_r_q;
  logic [ShiftW-1:0]    shift_q;
  logic [ChromBits-1:0] xo_mask;

  // xorshift step
  always_comb begin
    rng_next = rng_q ^ (rng_q >> XsShiftA);
    rng_next = rng_next ^ (rng_next << XsShiftB);
    rng_next = rng_next ^ (rng_next >> XsShiftC);
  end

  // Crossover mask: ones above the cut, flipped on an even draw
  always_comb begin
    xo_mask = {ChromBits{1'b1}} << shift_q;
    if (!draw_q[0]) begin
      xo_mask = ~xo_mask;
    end
  end

  // Generator state and valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_q <= ResetSeed;
      v_q   <= '0;
      dv_q  <= 1'b0;
    end else begin
      if (seed_we_i) begin
        rng_q <= (seed_i == '0) ? ResetSeed : seed_i;
      end else if (cmd_i.step) begin
        rng_q <= rng_next;
      end
      v_q  <= {v_q[3:1], cmd_i.step};
      dv_q <= v_q[4];
    end
  end

  // xorshift64* product, low 64 bits; three partial products in successive stages
  always_ff @(posedge clk_i) begin
    x1_q   <= rng_next;
    pll2_q <= 64'(x1_q[31:0]) * 64'(MultLo);
    xl2_q  <= x1_q[31:0];
    xh2_q  <= x1_q[63:32];
    c1_3_q <= xl2_q * MultHi;
    xh3_q  <= xh2_q;
    pll3_q <= pll2_q;
    c2_4_q <= xh3_q * MultLo;
    c1_4_q <= c1_3_q;
    pll4_q <= pll3_q;
    draw_q <= {pll4_q[63:32] + c1_4_q + c2_4_q, pll4_q[31:0]};
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ml_in_q <= mother_left_i;
      mr_in_q <= mother_right_i;
      fl_in_q <= father_left_i;
      fr_in_q <= father_right_i;
      code_q  <= recipe_code_i;
      rmask_q <= recipe_mask_i;
      mut_l_q <= '0;
      mut_r_q <= '0;
    end else if (cmd_i.use_draw && dv_q) begin
      unique case (cmd_i.op)
        OP_RECIPE_L:   left_q  <= code_q ^ (draw_q & rmask_q);
        OP_RECIPE_R:   right_q <= code_q ^ (draw_q & rmask_q);
        OP_XO_SHIFT:   shift_q <= draw_q[ShiftW-1:0];
        OP_XO_MOTHER:  left_q  <= (ml_in_q & xo_mask) | (mr_in_q & ~xo_mask);
        OP_XO_FATHER:  right_q <= (fl_in_q & xo_mask) | (fr_in_q & ~xo_mask);
        OP_SEX_SELECT: right_q <= draw_q[0] ? fr_in_q : fl_in_q;
        OP_MUT_L:      mut_l_q <= cmd_i.mut_first ? draw_q : (mut_l_q & draw_q);
        OP_MUT_R:      mut_r_q <= cmd_i.mut_first ? draw_q : (mut_r_q & draw_q);
        default:       shift_q <= shift_q;
      endcase
    end
    if (cmd_i.out_load) begin
      out_l_q <= left_q ^ mut_l_q;
      out_r_q <= right_q ^ mut_r_q;
    end
  end

  assign status_o.draw_valid = dv_q;
  assign child_left_o        = out_l_q;
  assign child_right_o       = out_r_q;

endmodule

// File: hdl/gcm_ctrl.sv
module gcm_ctrl #(
  parameter int unsigned MaxRounds = gcm_pkg::DefMaxRounds
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rounds_we_i,
  input  logic [gcm_pkg::RoundsW-1:0] rounds_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       kind_i,
  input  logic                       sex_chromosome_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output gcm_pkg::cmd_t              cmd_o,
  input  gcm_pkg::status_t           status_i
);
  import gcm_pkg::*;

  localparam int unsigned CntW = $clog2(4 + 2 * MaxRounds + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [RoundsW-1:0]  rounds_q;
  logic [CntW-1:0]     issue_q, cons_q, total_q, base_q;
  logic                kind_q, sex_q, out_valid_q;
  logic [CntW-1:0]     rounds_eff, base_d, mut_idx;
  logic                accept, out_load;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (int'(rounds_q) > int'(MaxRounds)) begin
      rounds_eff = CntW'(MaxRounds);
    end else begin
      rounds_eff = CntW'(rounds_q);
    end
    base_d = sex_chromosome_i ? CntW'(3) : CntW'(4);
  end

  // Map the draw index onto its use
  always_comb begin
    mut_idx         = cons_q - base_q;
    cmd_o.load      = accept;
    cmd_o.step      = (state_q == ST_RUN) && (issue_q != total_q);
    cmd_o.use_draw  = status_i.draw_valid;
    cmd_o.out_load  = out_load;
    cmd_o.mut_first = (mut_idx < CntW'(2));
    cmd_o.op        = OP_XO_SHIFT;
    if (kind_q) begin
      cmd_o.op = (cons_q == '0) ? OP_RECIPE_L : OP_RECIPE_R;
    end else if (cons_q == CntW'(0)) begin
      cmd_o.op = OP_XO_SHIFT;
    end else if (cons_q == CntW'(1)) begin
      cmd_o.op = OP_XO_MOTHER;
    end else if (cons_q == CntW'(2)) begin
      cmd_o.op = sex_q ? OP_SEX_SELECT : OP_XO_SHIFT;
    end else if (cons_q == CntW'(3) && !sex_q) begin
      cmd_o.op = OP_XO_FATHER;
    end else begin
      cmd_o.op = mut_idx[0] ? OP_MUT_R : OP_MUT_L;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rounds_q    <= ResetRounds;
      issue_q     <= '0;
      cons_q      <= '0;
      total_q     <= '0;
      base_q      <= '0;
      kind_q      <= 1'b0;
      sex_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rounds_we_i) begin
        rounds_q <= rounds_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            kind_q  <= kind_i;
            sex_q   <= sex_chromosome_i;
            base_q  <= base_d;
            total_q <= kind_i ? CntW'(2) : (base_d + (rounds_eff << 1));
            issue_q <= '0;
            cons_q  <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cmd_o.step) begin
            issue_q <= issue_q + CntW'(1);
          end
          if (status_i.draw_valid) begin
            cons_q <= cons_q + CntW'(1);
          end
          if (cons_q == total_q) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/genome_crossover_mutation.sv
// Each word needs N generator draws: 2 for a recipe word, 3 or 4 plus twice the
// mutation rounds for breeding. A new word is accepted only when the controller is
// idle, after the last result has moved to the output register; one generator step a
// cycle, then a five-stage pipeline forms the xorshift64* product.
// Reset: generator state 1, mutation rounds 6, no word in flight, output empty.
module genome_crossover_mutation #(
  parameter int unsigned MAX_MUTATION_ROUNDS = gcm_pkg::DefMaxRounds
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // input word
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [63:0] mother_left_i,
  input  logic [63:0] mother_right_i,
  input  logic [63:0] father_left_i,
  input  logic [63:0] father_right_i,
  input  logic        sex_chromosome_i,
  input  logic [63:0] recipe_code_i,
  input  logic [63:0] recipe_mask_i,
  // result word
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] child_left_o,
  output logic [63:0] child_right_o
);
  import gcm_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    seed_we, rounds_we;

  // Decode the register index; a seed write reloads the generator at once
  assign seed_we   = cfg_we_i && (cfg_idx_i == RegRngSeed);
  assign rounds_we = cfg_we_i && (cfg_idx_i == RegMutRounds);

  // Controller: hold the handshakes, count draws issued and consumed, and tag each
  // draw with its use (recipe words, crossover cut, crossover flip, sex select, mask rounds).
  gcm_ctrl #(
    .MaxRounds(MAX_MUTATION_ROUNDS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rounds_we_i     (rounds_we),
    .rounds_i        (cfg_wdata_i[RoundsW-1:0]),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .sex_chromosome_i(sex_chromosome_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cmd_o           (cmd),
    .status_i        (status)
  );

  // Datapath: generator, product pipeline, crossover and mutation registers, and the
  // output register that lets the next word in while a result waits.
  gcm_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_we_i     (seed_we),
    .seed_i        (cfg_wdata_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .mother_left_i (mother_left_i),
    .mother_right_i(mother_right_i),
    .father_left_i (father_left_i),
    .father_right_i(father_right_i),
    .recipe_code_i (recipe_code_i),
    .recipe_mask_i (recipe_mask_i),
    .child_left_o  (child_left_o),
    .child_right_o (child_right_o)
  );

endmodule
